>>> rtl/ipp_pkg.sv
// ipp request attribute parser shared types, codes and keyword tables
// no dependencies
package ipp_pkg;

   localparam int FormatBytesDefault    = 64;
   localparam int JobNameBytesDefault   = 64;
   localparam int WhichJobsBytesDefault = 32;
   localparam int UriBytesDefault       = 128;
   localparam int NumKw                 = 9;
   localparam int QueueDepth            = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
      logic       end_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  error_cause;
      logic [3:0]  field_kind;
      logic [31:0] field_value;
      logic [7:0]  char_index;
      logic        string_last;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_HDR, PH_TAG, PH_NLEN, PH_NAME, PH_VLEN, PH_SKIP, PH_CHARSET, PH_LANG,
      PH_STR, PH_INT, PH_BOOL, PH_JLLEN, PH_JLANG, PH_JNLEN, PH_JNAME
   } phase_type;

   typedef enum logic [3:0] {
      AT_OTHER, AT_CHARSET, AT_LANG, AT_FORMAT, AT_JOBNAME, AT_WHICH,
      AT_FIDELITY, AT_COPIES, AT_URI, AT_JOBID
   } attr_type;

   localparam logic [1:0] ST_PARSING = 2'd0;
   localparam logic [1:0] ST_ACCEPT  = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TRUNC     = 4'd1;
   localparam logic [3:0] ERR_RSV_DELIM = 4'd2;
   localparam logic [3:0] ERR_ORDER     = 4'd3;
   localparam logic [3:0] ERR_PREFIX    = 4'd4;
   localparam logic [3:0] ERR_NAME_CHAR = 4'd5;
   localparam logic [3:0] ERR_ORPHAN    = 4'd6;
   localparam logic [3:0] ERR_TAG       = 4'd7;
   localparam logic [3:0] ERR_LENGTH    = 4'd8;
   localparam logic [3:0] ERR_CONTENT   = 4'd9;

   localparam logic [3:0] FK_NONE      = 4'd0;
   localparam logic [3:0] FK_VERMAJOR  = 4'd1;
   localparam logic [3:0] FK_VERMINOR  = 4'd2;
   localparam logic [3:0] FK_OPID      = 4'd3;
   localparam logic [3:0] FK_REQID     = 4'd4;
   localparam logic [3:0] FK_FORMAT    = 4'd5;
   localparam logic [3:0] FK_JOBNAME   = 4'd6;
   localparam logic [3:0] FK_WHICH     = 4'd7;
   localparam logic [3:0] FK_URI       = 4'd8;
   localparam logic [3:0] FK_FIDELITY  = 4'd9;
   localparam logic [3:0] FK_COPIES    = 4'd10;
   localparam logic [3:0] FK_JOBID     = 4'd11;

   localparam logic [7:0] TAG_OPERATION = 8'h01;
   localparam logic [7:0] TAG_END       = 8'h03;
   localparam logic [7:0] TAG_DELIM_MAX = 8'h0F;
   localparam logic [7:0] TAG_INTEGER   = 8'h21;
   localparam logic [7:0] TAG_BOOLEAN   = 8'h22;
   localparam logic [7:0] TAG_NAME_LANG = 8'h36;
   localparam logic [7:0] TAG_NAME      = 8'h42;
   localparam logic [7:0] TAG_KEYWORD   = 8'h44;
   localparam logic [7:0] TAG_URI       = 8'h45;
   localparam logic [7:0] TAG_CHARSET   = 8'h47;
   localparam logic [7:0] TAG_LANGUAGE  = 8'h48;
   localparam logic [7:0] TAG_MIME      = 8'h49;

   localparam logic [31:0] IntMax    = 32'h7FFF_FFFF;
   localparam logic [15:0] LangMax   = 16'd63;
   localparam logic [15:0] JnameCap  = 16'd62;
   localparam logic [7:0]  PrintMax  = 8'h7E;

   localparam logic [4:0] KwLen [NumKw] = '{5'd18, 5'd27, 5'd15, 5'd8, 5'd10, 5'd22,
                                            5'd6, 5'd7, 5'd6};

   function automatic logic [7:0] kw_char(input int unsigned k, input logic [4:0] p);
      string s;
      begin
         case (k)
            0: s = "attributes-charset";
            1: s = "attributes-natural-language";
            2: s = "document-format";
            3: s = "job-name";
            4: s = "which-jobs";
            5: s = "ipp-attribute-fidelity";
            6: s = "copies";
            7: s = "job-uri";
            default: s = "job-id";
         endcase
         kw_char = (int'(p) < s.len()) ? s[p] : 8'h00;
      end
   endfunction

   function automatic logic [7:0] utf8_char(input logic [2:0] p);
      case (p)
         3'd0: utf8_char = "u";
         3'd1: utf8_char = "t";
         3'd2: utf8_char = "f";
         3'd3: utf8_char = "-";
         3'd4: utf8_char = "8";
         default: utf8_char = 8'h00;
      endcase
   endfunction

endpackage

>>> rtl/ipp_queue.sv
// short request queue between front and back parts
// depends on ipp_pkg
module ipp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  ipp_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output ipp_pkg::req_type out_data
);
   localparam int Depth = ipp_pkg::QueueDepth;

   ipp_pkg::req_type mem_ff [Depth];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_stall  = (count_ff == 2'(Depth));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

>>> rtl/ipp_parser.sv
// back part: byte-serial ipp request parser with registered result
// depends on ipp_pkg
module ipp_parser #(
   parameter int FORMAT_BYTES     = ipp_pkg::FormatBytesDefault,
   parameter int JOB_NAME_BYTES   = ipp_pkg::JobNameBytesDefault,
   parameter int WHICH_JOBS_BYTES = ipp_pkg::WhichJobsBytesDefault,
   parameter int URI_BYTES        = ipp_pkg::UriBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  ipp_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output ipp_pkg::rsp_type out_data
);
   localparam int          NKw       = ipp_pkg::NumKw;
   localparam logic [15:0] FmtLim    = 16'(FORMAT_BYTES);
   localparam logic [15:0] JobLim    = 16'(JOB_NAME_BYTES);
   localparam logic [15:0] WhichLim  = 16'(WHICH_JOBS_BYTES);
   localparam logic [15:0] UriLim    = 16'(URI_BYTES);
   localparam logic [15:0] JnCap     = (JobLim - 16'd1 < ipp_pkg::JnameCap) ?
                                       JobLim - 16'd1 : ipp_pkg::JnameCap;

   ipp_pkg::phase_type phase_ff, phase_in;
   ipp_pkg::attr_type  attr_ff, attr_in;
   logic [15:0] count_ff, count_in, vlen_ff, vlen_in, llen_ff, llen_in, npos_ff, npos_in;
   logic        group_ff, group_in, cs_ff, cs_in, lang_ff, lang_in, named_ff, named_in;
   logic        done_ff, done_in;
   logic [NKw-1:0] cand_ff, cand_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  tag_ff, tag_in;
   logic        out_valid_ff;
   ipp_pkg::rsp_type rsp_ff, rsp_in;
   logic        take;

   logic [7:0]  b;
   logic [1:0]  code;
   logic [3:0]  cause;
   logic [15:0] k16, lenw;
   logic [31:0] shifted;
   logic [4:0]  npos5;
   logic [7:0]  lc;
   logic [NKw-1:0] cand_nx;
   logic        ok;

   assign in_stall  = out_valid_ff && out_stall;
   assign take      = in_valid && !in_stall;
   assign out_valid = out_valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      phase_in = phase_ff; attr_in = attr_ff; count_in = count_ff; vlen_in = vlen_ff;
      llen_in = llen_ff; npos_in = npos_ff; group_in = group_ff; cs_in = cs_ff;
      lang_in = lang_ff; named_in = named_ff; done_in = done_ff; cand_in = cand_ff;
      acc_in = acc_ff; tag_in = tag_ff;
      rsp_in = '0; code = 2'd0; cause = ipp_pkg::ERR_NONE;
      b = in_data.data_byte;
      k16 = 16'd0; lenw = 16'd0; npos5 = 5'd0; lc = 8'd0; cand_nx = '0; ok = 1'b0;
      if (in_data.start_flag) begin
         phase_in = ipp_pkg::PH_HDR; count_in = 16'd0; acc_in = 32'd0;
         group_in = 1'b0; cs_in = 1'b0; lang_in = 1'b0; named_in = 1'b0;
         attr_in = ipp_pkg::AT_OTHER; vlen_in = 16'd0; llen_in = 16'd0;
         cand_in = '1; npos_in = 16'd0; done_in = 1'b0; tag_in = 8'd0;
      end
      shifted = {acc_in[23:0], b};
      if (done_in) begin
         rsp_in.status = ipp_pkg::ST_IGNORED;
      end else begin
         case (phase_in)
            ipp_pkg::PH_HDR: begin
               acc_in = shifted;
               count_in = count_in + 16'd1;
               if (count_in == 16'd1 || count_in == 16'd2) begin
                  rsp_in.field_kind = count_in[3:0];
                  rsp_in.field_value = {24'd0, b};
                  acc_in = 32'd0;
               end else if (count_in == 16'd4) begin
                  rsp_in.field_kind = ipp_pkg::FK_OPID;
                  rsp_in.field_value = {16'd0, shifted[15:0]};
                  acc_in = 32'd0;
               end else if (count_in >= 16'd8) begin
                  rsp_in.field_kind = ipp_pkg::FK_REQID;
                  rsp_in.field_value = shifted;
                  phase_in = ipp_pkg::PH_TAG; count_in = 16'd0; acc_in = 32'd0;
               end
            end
            ipp_pkg::PH_TAG: begin
               tag_in = b;
               if (b == ipp_pkg::TAG_END) begin
                  if (!cs_in || !lang_in) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_PREFIX;
                  end else begin
                     code = ipp_pkg::ST_ACCEPT;
                  end
               end else if (b == 8'h00) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_RSV_DELIM;
               end else if (b <= ipp_pkg::TAG_DELIM_MAX) begin
                  if (!group_in && b != ipp_pkg::TAG_OPERATION) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_ORDER;
                  end else if (group_in && (!cs_in || !lang_in)) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_PREFIX;
                  end else begin
                     group_in = 1'b1; named_in = 1'b0; attr_in = ipp_pkg::AT_OTHER;
                  end
               end else if (!group_in) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_ORDER;
               end else begin
                  phase_in = ipp_pkg::PH_NLEN; count_in = 16'd0; acc_in = 32'd0;
               end
            end
            ipp_pkg::PH_NLEN, ipp_pkg::PH_VLEN, ipp_pkg::PH_JLLEN,
            ipp_pkg::PH_JNLEN: begin
               acc_in = {16'd0, shifted[15:0]};
               k16 = shifted[15:0];
               if (count_in == 16'd0) begin
                  count_in = 16'd1;
               end else if (phase_in == ipp_pkg::PH_NLEN) begin
                  if (k16 == 16'd0) begin
                     if (!named_in) begin
                        code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_ORPHAN;
                     end else begin
                        phase_in = ipp_pkg::PH_VLEN; count_in = 16'd0; acc_in = 32'd0;
                     end
                  end else begin
                     vlen_in = k16; npos_in = 16'd0; cand_in = '1;
                     phase_in = ipp_pkg::PH_NAME; count_in = 16'd0; acc_in = 32'd0;
                  end
               end else if (phase_in == ipp_pkg::PH_VLEN) begin
                  vlen_in = k16;
                  count_in = 16'd0; acc_in = 32'd0;
                  if (!cs_in && attr_in != ipp_pkg::AT_CHARSET) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_PREFIX;
                  end else if (cs_in && !lang_in && attr_in != ipp_pkg::AT_LANG) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_PREFIX;
                  end else begin
                     case (attr_in)
                        ipp_pkg::AT_CHARSET: begin
                           if (tag_ff != ipp_pkg::TAG_CHARSET) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 != 16'd5) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_CHARSET;
                        end
                        ipp_pkg::AT_LANG: begin
                           if (tag_ff != ipp_pkg::TAG_LANGUAGE) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 == 16'd0 || k16 > ipp_pkg::LangMax) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_LANG;
                        end
                        ipp_pkg::AT_FORMAT: begin
                           if (tag_ff != ipp_pkg::TAG_MIME) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 == 16'd0 || k16 >= FmtLim) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_STR;
                        end
                        ipp_pkg::AT_JOBNAME: begin
                           if (tag_ff == ipp_pkg::TAG_NAME_LANG) begin
                              if (k16 < 16'd4) begin
                                 code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                              end else phase_in = ipp_pkg::PH_JLLEN;
                           end else if (tag_ff != ipp_pkg::TAG_NAME) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 == 16'd0 || k16 >= JobLim) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_STR;
                        end
                        ipp_pkg::AT_WHICH: begin
                           if (tag_ff != ipp_pkg::TAG_KEYWORD) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 == 16'd0 || k16 >= WhichLim) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_STR;
                        end
                        ipp_pkg::AT_URI: begin
                           if (tag_ff != ipp_pkg::TAG_URI) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 == 16'd0 || k16 >= UriLim) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_STR;
                        end
                        ipp_pkg::AT_FIDELITY: begin
                           if (tag_ff != ipp_pkg::TAG_BOOLEAN) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 != 16'd1) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_BOOL;
                        end
                        ipp_pkg::AT_COPIES, ipp_pkg::AT_JOBID: begin
                           if (tag_ff != ipp_pkg::TAG_INTEGER) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TAG;
                           end else if (k16 != 16'd4) begin
                              code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                           end else phase_in = ipp_pkg::PH_INT;
                        end
                        default: begin
                           phase_in = (k16 == 16'd0) ? ipp_pkg::PH_TAG : ipp_pkg::PH_SKIP;
                        end
                     endcase
                  end
               end else if (phase_in == ipp_pkg::PH_JLLEN) begin
                  if (k16 > ipp_pkg::LangMax || {1'b0, k16} + 17'd4 > {1'b0, vlen_in}) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                  end else begin
                     llen_in = k16; count_in = 16'd0; acc_in = 32'd0;
                     phase_in = (k16 == 16'd0) ? ipp_pkg::PH_JNLEN : ipp_pkg::PH_JLANG;
                  end
               end else begin
                  if ({1'b0, vlen_in} != 17'd4 + {1'b0, llen_in} + {1'b0, k16}) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                  end else if (k16 == 16'd0 || k16 > JnCap) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_LENGTH;
                  end else begin
                     llen_in = k16; count_in = 16'd0; acc_in = 32'd0;
                     phase_in = ipp_pkg::PH_JNAME;
                  end
               end
            end
            ipp_pkg::PH_NAME: begin
               ok = (b >= "a" && b <= "z") || (npos_in != 16'd0 &&
                    ((b >= "0" && b <= "9") || b == "_" || b == "." || b == "-"));
               npos5 = npos_in[4:0];
               for (int k = 0; k < NKw; k++) begin
                  cand_nx[k] = cand_in[k] && (npos_in[15:5] == 11'd0) &&
                               (npos5 < ipp_pkg::KwLen[k]) &&
                               (ipp_pkg::kw_char(k, npos5) == b);
               end
               if (!ok) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_NAME_CHAR;
               end else begin
                  cand_in = cand_nx;
                  npos_in = npos_in + 16'd1;
                  if (npos_in == vlen_in) begin
                     attr_in = ipp_pkg::AT_OTHER;
                     for (int k = 0; k < NKw; k++) begin
                        if (cand_nx[k] && {11'd0, ipp_pkg::KwLen[k]} == vlen_in) begin
                           attr_in = ipp_pkg::attr_type'(k + 1);
                        end
                     end
                     named_in = 1'b1;
                     phase_in = ipp_pkg::PH_VLEN; count_in = 16'd0; acc_in = 32'd0;
                  end
               end
            end
            ipp_pkg::PH_SKIP, ipp_pkg::PH_JLANG: begin
               lenw = (phase_in == ipp_pkg::PH_SKIP) ? vlen_in : llen_in;
               count_in = count_in + 16'd1;
               if (count_in >= lenw) begin
                  phase_in = (phase_in == ipp_pkg::PH_SKIP) ? ipp_pkg::PH_TAG :
                             ipp_pkg::PH_JNLEN;
                  count_in = 16'd0; acc_in = 32'd0;
               end
            end
            ipp_pkg::PH_CHARSET: begin
               lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
               if (count_in > 16'd4 || lc != ipp_pkg::utf8_char(count_in[2:0])) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_CONTENT;
               end else if (count_in == 16'd4) begin
                  cs_in = 1'b1; phase_in = ipp_pkg::PH_TAG; count_in = 16'd0;
                  acc_in = 32'd0;
               end else count_in = count_in + 16'd1;
            end
            ipp_pkg::PH_LANG: begin
               if (!((b >= "a" && b <= "z") || b == "-")) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_CONTENT;
               end else begin
                  count_in = count_in + 16'd1;
                  if (count_in >= vlen_in) begin
                     lang_in = 1'b1; phase_in = ipp_pkg::PH_TAG; count_in = 16'd0;
                     acc_in = 32'd0;
                  end
               end
            end
            ipp_pkg::PH_STR, ipp_pkg::PH_JNAME: begin
               lenw = (phase_in == ipp_pkg::PH_STR) ? vlen_in : llen_in;
               if (phase_in == ipp_pkg::PH_JNAME) begin
                  ok = (b != 8'h00);
                  rsp_in.field_kind = ipp_pkg::FK_JOBNAME;
               end else if (attr_in == ipp_pkg::AT_JOBNAME) begin
                  ok = (b >= 8'h20 && b != 8'h7F);
                  rsp_in.field_kind = ipp_pkg::FK_JOBNAME;
               end else begin
                  ok = (b >= 8'h20 && b <= ipp_pkg::PrintMax);
                  rsp_in.field_kind = (attr_in == ipp_pkg::AT_FORMAT) ? ipp_pkg::FK_FORMAT :
                                      (attr_in == ipp_pkg::AT_WHICH) ? ipp_pkg::FK_WHICH :
                                      ipp_pkg::FK_URI;
               end
               if (!ok) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_CONTENT;
               end else begin
                  rsp_in.field_value = {24'd0, b};
                  rsp_in.char_index = count_in[7:0];
                  rsp_in.string_last = (count_in + 16'd1 == lenw);
                  count_in = count_in + 16'd1;
                  if (count_in >= lenw) begin
                     phase_in = ipp_pkg::PH_TAG; count_in = 16'd0; acc_in = 32'd0;
                  end
               end
            end
            ipp_pkg::PH_INT: begin
               acc_in = shifted;
               count_in = count_in + 16'd1;
               if (count_in >= 16'd4) begin
                  if (shifted == 32'd0 || shifted > ipp_pkg::IntMax) begin
                     code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_CONTENT;
                  end else begin
                     rsp_in.field_kind = (attr_in == ipp_pkg::AT_COPIES) ?
                                         ipp_pkg::FK_COPIES : ipp_pkg::FK_JOBID;
                     rsp_in.field_value = shifted;
                     phase_in = ipp_pkg::PH_TAG; count_in = 16'd0; acc_in = 32'd0;
                  end
               end
            end
            ipp_pkg::PH_BOOL: begin
               if (b > 8'd1) begin
                  code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_CONTENT;
               end else begin
                  rsp_in.field_kind = ipp_pkg::FK_FIDELITY;
                  rsp_in.field_value = {24'd0, b};
                  phase_in = ipp_pkg::PH_TAG; count_in = 16'd0; acc_in = 32'd0;
               end
            end
            default: begin
               phase_in = ipp_pkg::PH_TAG; count_in = 16'd0; acc_in = 32'd0;
            end
         endcase
         if (code == ipp_pkg::ST_PARSING && in_data.end_flag) begin
            code = ipp_pkg::ST_REJECT; cause = ipp_pkg::ERR_TRUNC;
         end
         if (code != ipp_pkg::ST_PARSING) begin
            rsp_in = '0;
            rsp_in.status = code;
            rsp_in.error_cause = cause;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ipp_pkg::PH_HDR; attr_ff <= ipp_pkg::AT_OTHER; count_ff <= 16'd0;
         vlen_ff <= 16'd0; llen_ff <= 16'd0; npos_ff <= 16'd0; group_ff <= 1'b0;
         cs_ff <= 1'b0; lang_ff <= 1'b0; named_ff <= 1'b0; done_ff <= 1'b0;
         cand_ff <= '1; acc_ff <= 32'd0; tag_ff <= 8'd0; out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; attr_ff <= attr_in; count_ff <= count_in;
            vlen_ff <= vlen_in; llen_ff <= llen_in; npos_ff <= npos_in;
            group_ff <= group_in; cs_ff <= cs_in; lang_ff <= lang_in;
            named_ff <= named_in; done_ff <= done_in; cand_ff <= cand_in;
            acc_ff <= acc_in; tag_ff <= tag_in;
         end
         if (take) out_valid_ff <= 1'b1;
         else if (!out_stall) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_ff <= rsp_in;
   end
endmodule

>>> rtl/ipp_request_attribute_parser.sv
// ipp request attribute parser, top level
// depends on ipp_pkg, ipp_queue, ipp_parser
// One body byte is taken per cycle while neither side stalls, and each gives exactly one
// response: a two-entry request queue decouples the input from the parser, whose result
// register turns over every cycle while the response side does not stall; a request is
// held first in the queue and its response then in the parser result register, and the
// sustained rate is one byte per cycle while nothing stalls, set by the parser step.
module ipp_request_attribute_parser #(
   parameter int FORMAT_BYTES     = ipp_pkg::FormatBytesDefault,
   parameter int JOB_NAME_BYTES   = ipp_pkg::JobNameBytesDefault,
   parameter int WHICH_JOBS_BYTES = ipp_pkg::WhichJobsBytesDefault,
   parameter int URI_BYTES        = ipp_pkg::UriBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ipp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ipp_pkg::rsp_type rsp_data
);
   logic             q_valid, q_stall;
   ipp_pkg::req_type q_data;

   ipp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   ipp_parser #(
      .FORMAT_BYTES(FORMAT_BYTES), .JOB_NAME_BYTES(JOB_NAME_BYTES),
      .WHICH_JOBS_BYTES(WHICH_JOBS_BYTES), .URI_BYTES(URI_BYTES)
   ) u_parser (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_done_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ipp_pkg::ST_PARSING |->
         rsp_data.field_kind == ipp_pkg::FK_NONE)
      else $error("final response carries field data");
   a_ok_no_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ipp_pkg::ST_REJECT |->
         rsp_data.error_cause == ipp_pkg::ERR_NONE)
      else $error("cause without reject");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
`endif
endmodule
